[rtl/sclsc_pkg.sv]
// ----------------------------------------------------------------------------
// sclsc_pkg
// Shared types and character codes for the command line syntax checker.
// ----------------------------------------------------------------------------
package sclsc_pkg;

  // redirect run in progress
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_GT   = 2'd1,
    KIND_LT   = 2'd2
  } redir_kind_t;

  typedef logic [7:0] char_t;

  localparam char_t CH_PIPE   = 8'h7C;
  localparam char_t CH_GT     = 8'h3E;
  localparam char_t CH_LT     = 8'h3C;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_SQUOTE = 8'h27;
  localparam char_t CH_DQUOTE = 8'h22;

  // longest legal run of one redirect character
  localparam logic [1:0] MAX_REDIR_RUN = 2'd2;

endpackage

[rtl/shell_command_line_syntax_check.sv]
// ----------------------------------------------------------------------------
// shell_command_line_syntax_check
// Scans a command line one byte per request and gives a pass/fail verdict
// on the terminator request (pipes, quotes and redirects).
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid in_ready in_ch in_end_of_line | in
//  result  | out_valid out_ready out_line_valid     | out
//
//  one byte per clock sustained: an input register feeds the flag update,
//  whose verdict on a terminator is registered in the result register
//  only a terminator request makes a result; byte requests never stall
//  a terminator waits in the input register while the result register is
//  full, which then holds off in_ready
//  rst_n is synchronous: line state returns to line start, both stages empty
module shell_command_line_syntax_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_line_valid
);

  // input stage
  logic                  s1_valid_r;
  sclsc_pkg::char_t      s1_ch_r;
  logic                  s1_eol_r;

  // line state
  logic                    in_sq_r, in_sq_nxt;
  logic                    in_dq_r, in_dq_nxt;
  logic                    at_start_r, at_start_nxt;
  logic                    saw_ns_r, saw_ns_nxt;
  logic                    end_pipe_r, end_pipe_nxt;
  logic                    await_pipe_r, await_pipe_nxt;
  sclsc_pkg::redir_kind_t  kind_r, kind_nxt;
  logic [1:0]              run_r, run_nxt;
  logic                    await_tgt_r, await_tgt_nxt;
  logic                    failed_r, failed_nxt;

  // result stage
  logic out_valid_r;
  logic out_line_valid_r;

  logic s1_adv;
  logic out_free;
  logic blank, quoted, is_pipe, is_gt, is_lt;
  logic is_same, is_other;
  logic verdict;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_eol_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  assign out_valid      = out_valid_r;
  assign out_line_valid = out_line_valid_r;

  assign blank   = (s1_ch_r == sclsc_pkg::CH_SPACE);
  assign quoted  = in_sq_r || in_dq_r;
  assign is_pipe = (s1_ch_r == sclsc_pkg::CH_PIPE);
  assign is_gt   = (s1_ch_r == sclsc_pkg::CH_GT);
  assign is_lt   = (s1_ch_r == sclsc_pkg::CH_LT);
  assign is_same  = (kind_r == sclsc_pkg::KIND_GT) ? is_gt : is_lt;
  assign is_other = (kind_r == sclsc_pkg::KIND_GT) ? is_lt : is_gt;

  assign verdict = !failed_r && !in_sq_r && !in_dq_r && !end_pipe_r && saw_ns_r &&
                   !await_pipe_r && (kind_r == sclsc_pkg::KIND_NONE) && !await_tgt_r;

  always_comb begin
    in_sq_nxt      = in_sq_r;
    in_dq_nxt      = in_dq_r;
    at_start_nxt   = at_start_r;
    saw_ns_nxt     = saw_ns_r;
    end_pipe_nxt   = end_pipe_r;
    await_pipe_nxt = await_pipe_r;
    kind_nxt       = kind_r;
    run_nxt        = run_r;
    await_tgt_nxt  = await_tgt_r;
    failed_nxt     = failed_r;

    if (s1_eol_r) begin
      in_sq_nxt      = 1'b0;
      in_dq_nxt      = 1'b0;
      at_start_nxt   = 1'b1;
      saw_ns_nxt     = 1'b0;
      end_pipe_nxt   = 1'b0;
      await_pipe_nxt = 1'b0;
      kind_nxt       = sclsc_pkg::KIND_NONE;
      run_nxt        = 2'd0;
      await_tgt_nxt  = 1'b0;
      failed_nxt     = 1'b0;
    end else begin
      // leading pipe
      if (at_start_r && !blank) begin
        if (is_pipe) failed_nxt = 1'b1;
        at_start_nxt = 1'b0;
      end
      // pipe follow-up
      if (await_pipe_r && !blank) begin
        if (is_pipe) failed_nxt = 1'b1;
        await_pipe_nxt = 1'b0;
      end
      // redirect runs and targets
      if (kind_r != sclsc_pkg::KIND_NONE) begin
        if (is_same) begin
          if (run_r >= sclsc_pkg::MAX_REDIR_RUN) failed_nxt = 1'b1;
          else run_nxt = run_r + 2'd1;
        end else begin
          if (is_other || is_pipe) failed_nxt = 1'b1;
          else if (blank) await_tgt_nxt = 1'b1;
          kind_nxt = sclsc_pkg::KIND_NONE;
          run_nxt  = 2'd0;
        end
      end else if (await_tgt_r) begin
        if (!blank) begin
          if (is_pipe || is_gt || is_lt) failed_nxt = 1'b1;
          await_tgt_nxt = 1'b0;
        end
      end else if (!quoted && (is_gt || is_lt)) begin
        kind_nxt = is_gt ? sclsc_pkg::KIND_GT : sclsc_pkg::KIND_LT;
        run_nxt  = 2'd1;
      end
      // quotes and trailing pipe; a toggling quote leaves the pipe flag alone
      priority if (s1_ch_r == sclsc_pkg::CH_SQUOTE && !in_dq_r) begin
        in_sq_nxt = !in_sq_r;
      end else if (s1_ch_r == sclsc_pkg::CH_DQUOTE && !in_sq_r) begin
        in_dq_nxt = !in_dq_r;
      end else if (is_pipe && !quoted) begin
        end_pipe_nxt   = 1'b1;
        await_pipe_nxt = 1'b1;
      end else begin
        if (!blank) end_pipe_nxt = 1'b0;
      end
      if (!blank) saw_ns_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch_r  <= in_ch;
      s1_eol_r <= in_end_of_line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sq_r      <= 1'b0;
      in_dq_r      <= 1'b0;
      at_start_r   <= 1'b1;
      saw_ns_r     <= 1'b0;
      end_pipe_r   <= 1'b0;
      await_pipe_r <= 1'b0;
      kind_r       <= sclsc_pkg::KIND_NONE;
      run_r        <= 2'd0;
      await_tgt_r  <= 1'b0;
      failed_r     <= 1'b0;
    end else if (s1_adv) begin
      in_sq_r      <= in_sq_nxt;
      in_dq_r      <= in_dq_nxt;
      at_start_r   <= at_start_nxt;
      saw_ns_r     <= saw_ns_nxt;
      end_pipe_r   <= end_pipe_nxt;
      await_pipe_r <= await_pipe_nxt;
      kind_r       <= kind_nxt;
      run_r        <= run_nxt;
      await_tgt_r  <= await_tgt_nxt;
      failed_r     <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_eol_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_eol_r) begin
      out_line_valid_r <= verdict;
    end
  end

  // redirect kind and run length move together
  a_kind_run: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == sclsc_pkg::KIND_NONE) == (run_r == 2'd0))
    else $error("redirect kind and run length disagree");

  a_run_max: assert property (@(posedge clk) disable iff (!rst_n)
    run_r != 2'd3)
    else $error("redirect run beyond limit");

  // a terminator leaves the line state at line start
  a_eol_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_eol_r) |=> (at_start_r && !failed_r && !saw_ns_r && out_valid_r))
    else $error("terminator did not clear line state");

  // input side only stalls behind a terminator facing a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_eol_r && out_valid_r && !out_ready))
    else $error("unexpected input stall");

endmodule
